>>> sv/assert_macros.svh
// Assertion macros used by the range mapper top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle or later.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> cons) \
    else $error("assertion failed: implication");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> cons) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> sv/brm_pkg.sv
// Shared constants and types of the bisection range mapper.
package brm_pkg;

  // Default data width of the mapping arithmetic.
  localparam int DATA_WIDTH_DEF = 32;
  // Fixed width of the sample and result ports.
  localparam int SAMPLE_W = 32;
  // Width used to zero-extend between port and data widths.
  localparam int EXT_W = 64;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HIGH = 3'd3;

  // Control bits that travel with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic done;
  } brm_ctl_t;

endpackage

>>> sv/bisection_range_map.sv
// Top level of the bisection range mapper: config registers and step pipeline.
//
// Maps a signed sample from [input_low, input_high] onto
// [output_low, output_high] by repeated halving, with no divider.
// Input channel: a transaction is taken at a rising edge with start high
// and busy low. busy is high only during reset, so a new sample may be
// issued in every cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Indexes 0..3 select input_low, input_high,
// output_low and output_high; other indexes are ignored. Write only while
// no sample is in flight.
// Result channel: done pulses for one cycle with mapped_value. The result
// of a sample passes through the entry register and then every stage
// register in turn; results appear one per sample, in order. Each
// pipeline stage performs one bisection step; DATA_WIDTH + 1
// stages cover the deepest halving, so throughput is one sample a cycle.
// The receiver cannot stall, so the pipeline never holds.
// Reset: synchronous, clears all in-flight items and sets the registers
// to input 0..1 and output 0..1.
module bisection_range_map #(
  parameter int DATA_WIDTH = brm_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [brm_pkg::SAMPLE_W-1:0]  sample_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]         cfg_data,
  output logic                          done,
  output logic [brm_pkg::SAMPLE_W-1:0]  mapped_value
);
  import brm_pkg::*;

  `include "assert_macros.svh"

  localparam int NSTEPS  = DATA_WIDTH + 1;
  localparam int LATENCY = NSTEPS + 1;

  logic signed [DATA_WIDTH-1:0] input_low;
  logic signed [DATA_WIDTH-1:0] input_high;
  logic signed [DATA_WIDTH-1:0] output_low;
  logic signed [DATA_WIDTH-1:0] output_high;

  logic [EXT_W-1:0]             sample_ext;
  logic [EXT_W-1:0]             result_ext;
  logic signed [DATA_WIDTH-1:0] final_value;

  brm_ctl_t                     ctl_s [NSTEPS+1];
  logic signed [DATA_WIDTH-1:0] x_s   [NSTEPS+1];
  logic signed [DATA_WIDTH-1:0] il_s  [NSTEPS+1];
  logic signed [DATA_WIDTH-1:0] ih_s  [NSTEPS+1];
  logic signed [DATA_WIDTH-1:0] ol_s  [NSTEPS+1];
  logic signed [DATA_WIDTH-1:0] oh_s  [NSTEPS+1];
  logic signed [DATA_WIDTH-1:0] res_s [NSTEPS+1];

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Reset the configuration registers, or update one on a write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_low   <= '0;
      input_high  <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
      output_low  <= '0;
      output_high <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_LOW:   input_low   <= cfg_data;
        REG_INPUT_HIGH:  input_high  <= cfg_data;
        REG_OUTPUT_LOW:  output_low  <= cfg_data;
        REG_OUTPUT_HIGH: output_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bring the sample to the data width, taking bit DATA_WIDTH-1 as sign.
  assign sample_ext = {{(EXT_W-SAMPLE_W){1'b0}}, sample_value};

  // Capture an accepted transaction into the entry stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else begin
      ctl_s[0].valid <= start && !busy;
      ctl_s[0].done  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_s[0]   <= sample_ext[DATA_WIDTH-1:0];
    il_s[0]  <= input_low;
    ih_s[0]  <= input_high;
    ol_s[0]  <= output_low;
    oh_s[0]  <= output_high;
    res_s[0] <= '0;
  end

  // Chain one bisection step per stage.
  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    brm_stage #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .in_ctl (ctl_s[i]),
      .in_x   (x_s[i]),
      .in_il  (il_s[i]),
      .in_ih  (ih_s[i]),
      .in_ol  (ol_s[i]),
      .in_oh  (oh_s[i]),
      .in_res (res_s[i]),
      .out_ctl(ctl_s[i+1]),
      .out_x  (x_s[i+1]),
      .out_il (il_s[i+1]),
      .out_ih (ih_s[i+1]),
      .out_ol (ol_s[i+1]),
      .out_oh (oh_s[i+1]),
      .out_res(res_s[i+1])
    );
  end

  // Drive the result from the last stage; fall back to the low bound.
  assign final_value  = ctl_s[NSTEPS].done ? res_s[NSTEPS] : ol_s[NSTEPS];
  assign result_ext   = {{(EXT_W-DATA_WIDTH){1'b0}}, final_value};
  assign mapped_value = result_ext[SAMPLE_W-1:0];
  assign done         = ctl_s[NSTEPS].valid;

  // Every accepted sample yields its result at the end of the pipeline.
  `ASSERT_IMPLIES(a_latency, clk, rst, start && !busy, ##LATENCY done)
  // The pipeline is deep enough to settle every item.
  `ASSERT_IMPLIES(a_settled, clk, rst, ctl_s[NSTEPS].valid, ctl_s[NSTEPS].done)
  // An accepted sample always enters the entry stage, not yet settled.
  `ASSERT_NEXT(a_entry, clk, rst, start && !busy, ctl_s[0].valid && !ctl_s[0].done)

endmodule

>>> sv/brm_stage.sv
// One registered bisection step of the range mapper pipeline.
module brm_stage #(
  parameter int DATA_WIDTH = brm_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  brm_pkg::brm_ctl_t            in_ctl,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_il,
  input  logic signed [DATA_WIDTH-1:0] in_ih,
  input  logic signed [DATA_WIDTH-1:0] in_ol,
  input  logic signed [DATA_WIDTH-1:0] in_oh,
  input  logic signed [DATA_WIDTH-1:0] in_res,
  output brm_pkg::brm_ctl_t            out_ctl,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic signed [DATA_WIDTH-1:0] out_il,
  output logic signed [DATA_WIDTH-1:0] out_ih,
  output logic signed [DATA_WIDTH-1:0] out_ol,
  output logic signed [DATA_WIDTH-1:0] out_oh,
  output logic signed [DATA_WIDTH-1:0] out_res
);
  import brm_pkg::*;

  logic signed [DATA_WIDTH:0]   in_sum;
  logic signed [DATA_WIDTH:0]   out_sum;
  logic signed [DATA_WIDTH-1:0] in_mid;
  logic signed [DATA_WIDTH-1:0] out_mid;
  logic                         done_next;
  logic signed [DATA_WIDTH-1:0] res_next;
  logic signed [DATA_WIDTH-1:0] il_next;
  logic signed [DATA_WIDTH-1:0] ih_next;
  logic signed [DATA_WIDTH-1:0] ol_next;
  logic signed [DATA_WIDTH-1:0] oh_next;

  // Form floor midpoints one bit wider so the sums never overflow.
  assign in_sum  = {in_il[DATA_WIDTH-1], in_il} + {in_ih[DATA_WIDTH-1], in_ih};
  assign out_sum = {in_ol[DATA_WIDTH-1], in_ol} + {in_oh[DATA_WIDTH-1], in_oh};
  assign in_mid  = in_sum[DATA_WIDTH:1];
  assign out_mid = out_sum[DATA_WIDTH:1];

  // Settle the item or keep the half of both ranges that holds the sample.
  // A reversed input range is always settled by the two clamp tests.
  always_comb begin
    done_next = in_ctl.done;
    res_next  = in_res;
    il_next   = in_il;
    ih_next   = in_ih;
    ol_next   = in_ol;
    oh_next   = in_oh;
    if (!in_ctl.done) begin
      if (in_x >= in_ih) begin
        done_next = 1'b1;
        res_next  = in_oh;
      end else if (in_x <= in_il) begin
        done_next = 1'b1;
        res_next  = in_ol;
      end else if (in_ol == in_oh) begin
        done_next = 1'b1;
        res_next  = in_ol;
      end else if (in_il == in_mid) begin
        done_next = 1'b1;
        res_next  = out_mid;
      end else if (in_x <= in_mid) begin
        ih_next = in_mid;
        oh_next = out_mid;
      end else begin
        il_next = in_mid + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
        ol_next = out_mid;
      end
    end
  end

  // Advance the control bits; clear them on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.done  <= done_next;
    end
  end

  // Advance the payload.
  always_ff @(posedge clk) begin
    out_x   <= in_x;
    out_il  <= il_next;
    out_ih  <= ih_next;
    out_ol  <= ol_next;
    out_oh  <= oh_next;
    out_res <= res_next;
  end

endmodule
